[hw/rtl/expression_token_lexer_defines.svh]
// Assertion macros for the expression token lexer.
`ifndef EXPRESSION_TOKEN_LEXER_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ETL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ETL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/etl_pkg.sv]
// Types and constants shared by the expression token lexer.
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_expression;
	} char_word_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [7:0]  symbol;
		logic [2:0]  function_index;
		logic [31:0] mantissa;
		logic [3:0]  fraction_digits;
		logic        number_saturated;
		logic        is_unary;
		logic        last_in_run;
	} token_word_t;

	localparam logic [3:0] TK_NUMBER   = 4'd0;
	localparam logic [3:0] TK_VARIABLE = 4'd1;
	localparam logic [3:0] TK_FUNCTION = 4'd2;
	localparam logic [3:0] TK_LPAREN   = 4'd3;
	localparam logic [3:0] TK_RPAREN   = 4'd4;
	localparam logic [3:0] TK_SEP      = 4'd5;
	localparam logic [3:0] TK_ASSIGN   = 4'd6;
	localparam logic [3:0] TK_OPERATOR = 4'd7;
	localparam logic [3:0] TK_UNKNOWN  = 4'd8;
	localparam logic [3:0] TK_END      = 4'd9;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	// clears the lower-case bit of a letter
	localparam logic [7:0] UPCASE_MASK = 8'hDF;

	// index 0 is SUM
	localparam logic [4:0][23:0] FUNC_NAMES = {"PRD", "AVG", "MAX", "MIN", "SUM"};

endpackage

`default_nettype wire

[hw/rtl/expression_token_lexer.sv]
// Characters are registered at the input and their tokens in the token buffer.
// Throughput: one character per cycle while each causes at most one token
// and is taken; more tokens per character hold the lexer (one output port).
// Reset: asynchronous, active low; clears the scan state and both the input
// and token buffers; the name letter store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "expression_token_lexer_defines.svh"

module expression_token_lexer #(
	parameter int MANTISSA_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  etl_pkg::char_word_t char_word,
	output logic                token_valid,
	input  logic                token_ready,
	output etl_pkg::token_word_t token_word
);
	import etl_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NUM  = 2'd1;
	localparam logic [1:0] MODE_NAME = 2'd2;
	localparam logic [1:0] MODE_DROP = 2'd3;

	localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;

	function automatic token_word_t simple_tok(logic [3:0] kind, logic [7:0] sym);
		token_word_t t;
		t = '0;
		t.token_kind = kind;
		t.symbol = sym;
		return t;
	endfunction

	function automatic token_word_t num_tok(logic [MANTISSA_BITS-1:0] v, logic [3:0] f,
			logic o);
		token_word_t t;
		t = '0;
		t.token_kind = TK_NUMBER;
		t.mantissa = 32'(v);
		t.fraction_digits = f;
		t.number_saturated = o;
		return t;
	endfunction

	function automatic token_word_t name_tok(logic [2:0] len, logic [7:0] l0,
			logic [7:0] l1, logic [7:0] l2);
		token_word_t t;
		logic [23:0] up;
		t = '0;
		up = {l0 & UPCASE_MASK, l1 & UPCASE_MASK, l2 & UPCASE_MASK};
		t.token_kind = TK_UNKNOWN;
		if (len == 3'd1) begin
			t.token_kind = TK_VARIABLE;
			t.symbol = l0;
		end else if (len == 3'd3) begin
			for (int k = 4; k >= 0; k--) begin
				if (up == FUNC_NAMES[k]) begin
					t.token_kind = TK_FUNCTION;
					t.function_index = 3'(k);
				end
			end
		end
		return t;
	endfunction

	// input stage
	logic       valid_s1;
	char_word_t word_s1;

	// scan state
	logic [1:0]               mode_q;
	logic                     expect_q;
	logic [MANTISSA_BITS-1:0] value_q;
	logic [3:0]               frac_q;
	logic [1:0]               dots_q;
	logic                     ovf_q;
	logic [2:0]               nlen_q;
	logic [7:0]               letters_q [3];

	// token buffer
	token_word_t obuf_q [3];
	logic [1:0]  ocnt_q;

	logic pop, buf_free, move;

	// next state and results
	logic [1:0]               mode_n;
	logic                     expect_n;
	logic [MANTISSA_BITS-1:0] value_n;
	logic [3:0]               frac_n;
	logic [1:0]               dots_n;
	logic                     ovf_n;
	logic [2:0]               nlen_n;
	logic [7:0]               letters_n [3];
	token_word_t              res [3];
	logic [1:0]               n;

	// number accumulate
	logic [7:0]               c;
	logic                     is_digit, is_dot, is_letter;
	logic [MANTISSA_BITS-1:0] base_v;
	logic [3:0]               base_f;
	logic [1:0]               base_d;
	logic                     base_o;
	logic [MANTISSA_BITS+3:0] bx, ext;
	logic                     fits;
	logic [MANTISSA_BITS-1:0] na_v;
	logic [3:0]               na_f;
	logic [1:0]               na_d;
	logic                     na_o;

	assign pop         = token_valid && token_ready;
	assign buf_free    = (ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && pop);
	assign move        = valid_s1 && buf_free;
	assign char_ready  = !valid_s1 || move;
	assign token_valid = ocnt_q != 2'd0;
	assign token_word  = obuf_q[0];

	assign c         = word_s1.char_code;
	assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_dot    = c == CH_DOT;
	assign is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));

	// continue from the running number or start from zero
	always_comb begin
		if (mode_q == MODE_NUM) begin
			base_v = value_q;
			base_f = frac_q;
			base_d = dots_q;
			base_o = ovf_q;
		end else begin
			base_v = '0;
			base_f = 4'd0;
			base_d = 2'd0;
			base_o = 1'b0;
		end
		bx   = {4'b0000, base_v};
		ext  = (bx << 3) + (bx << 1) + (MANTISSA_BITS + 4)'(c[3:0]);
		fits = ext[MANTISSA_BITS+3:MANTISSA_BITS] == 4'd0;
		na_v = base_v;
		na_f = base_f;
		na_d = base_d;
		na_o = base_o;
		if (is_dot) begin
			if (base_d < 2'd2) begin
				na_d = base_d + 2'd1;
			end
		end else if (base_d == 2'd0) begin
			if (fits) begin
				na_v = ext[MANTISSA_BITS-1:0];
			end else begin
				na_v = MANT_MAX;
				na_o = 1'b1;
			end
		end else if ((base_d == 2'd1) && (base_f < 4'd9) && fits) begin
			na_v = ext[MANTISSA_BITS-1:0];
			na_f = base_f + 4'd1;
		end
	end

	always_comb begin
		token_word_t t;
		mode_n    = mode_q;
		expect_n  = expect_q;
		value_n   = value_q;
		frac_n    = frac_q;
		dots_n    = dots_q;
		ovf_n     = ovf_q;
		nlen_n    = nlen_q;
		letters_n = letters_q;
		res[0]    = '0;
		res[1]    = '0;
		res[2]    = '0;
		n         = 2'd0;
		t         = '0;

		if ((mode_q == MODE_NUM) && (is_digit || is_dot)) begin
			value_n = na_v;
			frac_n  = na_f;
			dots_n  = na_d;
			ovf_n   = na_o;
		end else if ((mode_q == MODE_NAME) && is_letter) begin
			if (nlen_q < 3'd3) begin
				letters_n[nlen_q[1:0]] = c;
			end
			if (nlen_q < 3'd4) begin
				nlen_n = nlen_q + 3'd1;
			end
		end else if (mode_q != MODE_DROP) begin
			if (mode_q == MODE_NUM) begin
				res[n]   = num_tok(value_q, frac_q, ovf_q);
				n        = n + 2'd1;
				expect_n = 1'b0;
				mode_n   = MODE_IDLE;
			end else if (mode_q == MODE_NAME) begin
				t      = name_tok(nlen_q, letters_q[0], letters_q[1], letters_q[2]);
				res[n] = t;
				n      = n + 2'd1;
				if (t.token_kind == TK_VARIABLE) begin
					expect_n = 1'b0;
					mode_n   = MODE_IDLE;
				end else if (t.token_kind == TK_FUNCTION) begin
					expect_n = 1'b1;
					mode_n   = MODE_IDLE;
				end else begin
					mode_n = MODE_DROP;
				end
			end
			if (mode_n != MODE_DROP) begin
				if (is_digit || is_dot) begin
					mode_n  = MODE_NUM;
					value_n = na_v;
					frac_n  = na_f;
					dots_n  = na_d;
					ovf_n   = na_o;
				end else if (is_letter) begin
					mode_n       = MODE_NAME;
					letters_n[0] = c;
					nlen_n       = 3'd1;
				end else begin
					case (c) inside
						CH_LPAREN: begin
							res[n]   = simple_tok(TK_LPAREN, c);
							n        = n + 2'd1;
							expect_n = 1'b1;
						end
						CH_RPAREN: begin
							res[n]   = simple_tok(TK_RPAREN, c);
							n        = n + 2'd1;
							expect_n = 1'b0;
						end
						CH_SEMI: begin
							res[n]   = simple_tok(TK_SEP, c);
							n        = n + 2'd1;
							expect_n = 1'b1;
						end
						CH_EQUAL: begin
							res[n]   = simple_tok(TK_ASSIGN, c);
							n        = n + 2'd1;
							expect_n = 1'b1;
						end
						CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: begin
							t          = simple_tok(TK_OPERATOR, c);
							t.is_unary = expect_n && ((c == CH_PLUS) || (c == CH_MINUS));
							res[n]     = t;
							n          = n + 2'd1;
							expect_n   = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
		end

		if (word_s1.end_of_expression) begin
			if (mode_n == MODE_NUM) begin
				res[n] = num_tok(value_n, frac_n, ovf_n);
				n      = n + 2'd1;
			end else if (mode_n == MODE_NAME) begin
				res[n] = name_tok(nlen_n, letters_n[0], letters_n[1], letters_n[2]);
				n      = n + 2'd1;
			end
			res[n]   = simple_tok(TK_END, 8'h00);
			n        = n + 2'd1;
			mode_n   = MODE_IDLE;
			expect_n = 1'b1;
			value_n  = '0;
			frac_n   = 4'd0;
			dots_n   = 2'd0;
			ovf_n    = 1'b0;
			nlen_n   = 3'd0;
		end

		if (n != 2'd0) begin
			res[n - 2'd1].last_in_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ocnt_q   <= 2'd0;
			mode_q   <= MODE_IDLE;
			expect_q <= 1'b1;
			value_q  <= '0;
			frac_q   <= 4'd0;
			dots_q   <= 2'd0;
			ovf_q    <= 1'b0;
			nlen_q   <= 3'd0;
		end else begin
			if (char_ready) begin
				valid_s1 <= char_valid;
			end
			if (move) begin
				ocnt_q   <= n;
				mode_q   <= mode_n;
				expect_q <= expect_n;
				value_q  <= value_n;
				frac_q   <= frac_n;
				dots_q   <= dots_n;
				ovf_q    <= ovf_n;
				nlen_q   <= nlen_n;
			end else if (pop) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			word_s1 <= char_word;
		end
		if (move) begin
			letters_q <= letters_n;
			obuf_q    <= res;
		end else if (pop) begin
			obuf_q[0] <= obuf_q[1];
			obuf_q[1] <= obuf_q[2];
		end
	end

	`ETL_ASSERT_NOW(a_last_only_at_tail, token_valid && (ocnt_q > 2'd1), !token_word.last_in_run, "last_in_run set before end of run")
	`ETL_ASSERT_NOW(a_end_is_last, token_valid && (token_word.token_kind == TK_END), token_word.last_in_run, "end token not last in run")
	`ETL_ASSERT_NEXT(a_eoe_resets, move && word_s1.end_of_expression, (mode_q == MODE_IDLE) && expect_q && (nlen_q == 3'd0), "scan state not cleared after end of expression")

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the expression token lexer: directed table, then random expressions.
`timescale 1ns / 1ps

module tb;
	import etl_pkg::*;

	localparam int MANT_BITS = 32;
	localparam logic [63:0] MANT_MAX = ((64'd1 << (MANT_BITS - 1)) * 2) - 1;
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_CHARS = 100;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [7:0] PUNCT [9] = '{CH_LPAREN, CH_RPAREN, CH_SEMI, CH_EQUAL, CH_PLUS,
		CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
	localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_NAME, SCAN_DROP} scan_mode_t;

	typedef struct {
		logic [7:0]  ch;
		logic        eoe;
		bit          typed;
		token_word_t tok;
	} char_row_t;

	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_ready;
	char_word_t  char_word;
	logic        token_valid;
	logic        token_ready;
	token_word_t token_word;

	token_word_t lexed_tokens [$];
	token_word_t step_toks [$];
	logic [7:0]  expr_chars [$];
	char_row_t   directed_rows [30];
	int          mismatch_count;
	int          idle_cycles;
	bit          quiet_phase;

	scan_mode_t  lx_mode;
	bit          lx_operand;
	logic [63:0] lx_value;
	logic [3:0]  lx_frac;
	logic [1:0]  lx_dots;
	bit          lx_sat;
	logic [2:0]  lx_len;
	logic [7:0]  lx_name [3];

	expression_token_lexer #(.MANTISSA_BITS(MANT_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_word(char_word),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_word(token_word)
	);

	always #4 clk = ~clk;

	function automatic token_word_t tok(logic [3:0] kind, logic [7:0] sym, logic [2:0] fidx,
			logic [63:0] mant, logic [3:0] frac, logic sat, logic unary);
		token_word_t t;
		t = '0;
		t.token_kind = kind;
		t.symbol = sym;
		t.function_index = fidx;
		t.mantissa = mant[31:0];
		t.fraction_digits = frac;
		t.number_saturated = sat;
		t.is_unary = unary;
		return t;
	endfunction

	function automatic void reset_lexer();
		lx_mode = SCAN_IDLE;
		lx_operand = 1'b1;
		lx_value = '0;
		lx_frac = '0;
		lx_dots = '0;
		lx_sat = 1'b0;
		lx_len = '0;
	endfunction

	function automatic void accumulate(logic [7:0] c);
		logic [63:0] d;
		bit fits;
		if (c == CH_DOT) begin
			if (lx_dots < 2) lx_dots++;
			return;
		end
		d = 64'(c - CH_ZERO);
		fits = lx_value <= (MANT_MAX - d) / 10;
		if (lx_dots == 0) begin
			if (fits) begin
				lx_value = lx_value * 10 + d;
			end else begin
				lx_value = MANT_MAX;
				lx_sat = 1'b1;
			end
		end else if (lx_dots == 1 && lx_frac < 9 && fits) begin
			lx_value = lx_value * 10 + d;
			lx_frac++;
		end
	endfunction

	function automatic void flush_number();
		step_toks.push_back(tok(TK_NUMBER, 8'h00, 3'd0, lx_value, lx_frac, lx_sat, 1'b0));
		lx_operand = 1'b0;
		lx_mode = SCAN_IDLE;
	endfunction

	function automatic void flush_name();
		bit found;
		found = 1'b0;
		if (lx_len == 1) begin
			step_toks.push_back(tok(TK_VARIABLE, lx_name[0], 3'd0, '0, '0, 1'b0, 1'b0));
			lx_operand = 1'b0;
			lx_mode = SCAN_IDLE;
			return;
		end
		if (lx_len == 3) begin
			for (int k = 0; k < 5; k++) begin
				if (!found && {lx_name[0] & UPCASE_MASK, lx_name[1] & UPCASE_MASK,
						lx_name[2] & UPCASE_MASK} == FUNC_NAMES[k]) begin
					step_toks.push_back(tok(TK_FUNCTION, 8'h00, 3'(k), '0, '0, 1'b0, 1'b0));
					lx_operand = 1'b1;
					lx_mode = SCAN_IDLE;
					found = 1'b1;
				end
			end
		end
		if (!found) begin
			step_toks.push_back(tok(TK_UNKNOWN, 8'h00, 3'd0, '0, '0, 1'b0, 1'b0));
			lx_mode = SCAN_DROP;
		end
	endfunction

	function automatic void lex_char(char_word_t w);
		logic [7:0] c;
		bit is_num;
		bit is_alpha;
		c = w.char_code;
		is_num = (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT;
		is_alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
		step_toks = {};
		if (lx_mode == SCAN_NUMBER && is_num) begin
			accumulate(c);
		end else if (lx_mode == SCAN_NAME && is_alpha) begin
			if (lx_len < 3) lx_name[lx_len] = c;
			if (lx_len < 4) lx_len++;
		end else if (lx_mode != SCAN_DROP) begin
			if (lx_mode == SCAN_NUMBER) flush_number();
			else if (lx_mode == SCAN_NAME) flush_name();
			if (lx_mode != SCAN_DROP) begin
				if (is_num) begin
					lx_mode = SCAN_NUMBER;
					lx_value = '0;
					lx_frac = '0;
					lx_dots = '0;
					lx_sat = 1'b0;
					accumulate(c);
				end else if (is_alpha) begin
					lx_mode = SCAN_NAME;
					lx_name[0] = c;
					lx_len = 3'd1;
				end else begin
					case (c) inside
						CH_LPAREN: begin
							step_toks.push_back(tok(TK_LPAREN, c, 3'd0, '0, '0, 1'b0, 1'b0));
							lx_operand = 1'b1;
						end
						CH_RPAREN: begin
							step_toks.push_back(tok(TK_RPAREN, c, 3'd0, '0, '0, 1'b0, 1'b0));
							lx_operand = 1'b0;
						end
						CH_SEMI: begin
							step_toks.push_back(tok(TK_SEP, c, 3'd0, '0, '0, 1'b0, 1'b0));
							lx_operand = 1'b1;
						end
						CH_EQUAL: begin
							step_toks.push_back(tok(TK_ASSIGN, c, 3'd0, '0, '0, 1'b0, 1'b0));
							lx_operand = 1'b1;
						end
						CH_PLUS, CH_MINUS: begin
							step_toks.push_back(tok(TK_OPERATOR, c, 3'd0, '0, '0, 1'b0, lx_operand));
							lx_operand = 1'b1;
						end
						CH_STAR, CH_SLASH, CH_CARET: begin
							step_toks.push_back(tok(TK_OPERATOR, c, 3'd0, '0, '0, 1'b0, 1'b0));
							lx_operand = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
		end
		if (w.end_of_expression) begin
			if (lx_mode == SCAN_NUMBER) flush_number();
			else if (lx_mode == SCAN_NAME) flush_name();
			step_toks.push_back(tok(TK_END, 8'h00, 3'd0, '0, '0, 1'b0, 1'b0));
			reset_lexer();
		end
		if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_in_run = 1'b1;
	endfunction

	function automatic int idle_draw();
		if (quiet_phase) return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'($urandom_range(0, 25));
	endfunction

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic check_token(token_word_t got);
		token_word_t want;
		if (lexed_tokens.size() == 0) begin
			$display("%0t: token word with none expected, got kind %0h symbol %0h", $time,
				got.token_kind, got.symbol);
			mismatch_count++;
			return;
		end
		want = lexed_tokens.pop_front();
		cmp_field("token_kind", want.token_kind, got.token_kind);
		cmp_field("symbol", want.symbol, got.symbol);
		cmp_field("function_index", want.function_index, got.function_index);
		cmp_field("mantissa", want.mantissa, got.mantissa);
		cmp_field("fraction_digits", want.fraction_digits, got.fraction_digits);
		cmp_field("number_saturated", want.number_saturated, got.number_saturated);
		cmp_field("is_unary", want.is_unary, got.is_unary);
		cmp_field("last_in_run", want.last_in_run, got.last_in_run);
	endtask

	task automatic send_char(logic [7:0] c, logic eoe, bit typed, token_word_t typed_tok);
		int gap;
		char_word_t w;
		gap = idle_draw();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.char_code = c;
		w.end_of_expression = eoe;
		char_valid <= 1'b1;
		char_word <= w;
		do @(posedge clk); while (!char_ready);
		lex_char(w);
		// typed rows each cause a single word
		if (typed) begin
			typed_tok.last_in_run = 1'b1;
			step_toks = {typed_tok};
		end
		foreach (step_toks[i]) lexed_tokens.push_back(step_toks[i]);
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		do @(posedge clk); while (lexed_tokens.size() != 0);
	endtask

	task automatic build_expr();
		int pieces;
		int r;
		int n;
		int k;
		expr_chars = {};
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) expr_chars.push_back(8'($urandom_range(0, 255)));
			return;
		end
		pieces = $urandom_range(1, 10);
		for (int p = 0; p < pieces; p++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				if ($urandom_range(0, 19) == 0) begin
					repeat ($urandom_range(1, 2)) expr_chars.push_back(CH_DOT);
				end else begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
					repeat (n) expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					if ($urandom_range(0, 1)) begin
						expr_chars.push_back(CH_DOT);
						n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
						repeat (n) expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					end
					if ($urandom_range(0, 7) == 0) begin
						expr_chars.push_back(CH_DOT);
						repeat ($urandom_range(0, 3))
							expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					end
				end
			end else if (r < 45) begin
				expr_chars.push_back(rand_letter());
			end else if (r < 55) begin
				k = $urandom_range(0, 4);
				for (int i = 2; i >= 0; i--)
					expr_chars.push_back(FUNC_NAMES[k][i * 8 +: 8] |
						($urandom_range(0, 1) ? ~UPCASE_MASK : 8'h00));
				expr_chars.push_back(CH_LPAREN);
			end else if (r < 85) begin
				expr_chars.push_back(PUNCT[$urandom_range(0, 8)]);
			end else if (r < 90) begin
				expr_chars.push_back(BLANKS[$urandom_range(0, 5)]);
			end else if (r < 95) begin
				expr_chars.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(2, 6)) expr_chars.push_back(rand_letter());
			end
			if (r < 45 || r >= 95) begin
				if (p < pieces - 1 || $urandom_range(0, 1))
					expr_chars.push_back($urandom_range(0, 2) ? PUNCT[$urandom_range(0, 8)]
						: BLANKS[$urandom_range(0, 5)]);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && char_ready) || (token_valid && token_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("expression_token_lexer test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			int stall;
			stall = idle_draw();
			if (stall > 0) begin
				token_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			token_ready <= 1'b1;
			do @(posedge clk); while (!token_valid);
			check_token(token_word);
		end
	end

	initial begin
		int sent;
		clk = 1'b0;
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_word = '0;
		token_ready = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		quiet_phase = 1'b0;
		sent = 0;
		reset_lexer();
		lx_name = '{8'h00, 8'h00, 8'h00};

		directed_rows = '{
			'{CH_PLUS, 1'b0, 1'b1, tok(TK_OPERATOR, CH_PLUS, 3'd0, '0, '0, 1'b0, 1'b1)},
			'{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
			'{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
			'{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
			'{"9", 1'b0, 1'b0, '0},
			'{CH_CARET, 1'b0, 1'b0, '0},
			'{CH_DOT, 1'b0, 1'b0, '0},
			'{CH_DOT, 1'b0, 1'b0, '0},
			'{"3", 1'b0, 1'b0, '0},
			'{CH_RPAREN, 1'b0, 1'b0, '0},
			'{CH_STAR, 1'b0, 1'b1, tok(TK_OPERATOR, CH_STAR, 3'd0, '0, '0, 1'b0, 1'b0)},
			'{"m", 1'b0, 1'b0, '0},
			'{"A", 1'b0, 1'b0, '0},
			'{"x", 1'b0, 1'b0, '0},
			'{CH_LPAREN, 1'b0, 1'b0, '0},
			'{"y", 1'b0, 1'b0, '0},
			'{" ", 1'b0, 1'b0, '0},
			'{CH_EQUAL, 1'b0, 1'b1, tok(TK_ASSIGN, CH_EQUAL, 3'd0, '0, '0, 1'b0, 1'b0)},
			'{CH_MINUS, 1'b0, 1'b1, tok(TK_OPERATOR, CH_MINUS, 3'd0, '0, '0, 1'b0, 1'b1)},
			'{CH_SEMI, 1'b0, 1'b1, tok(TK_SEP, CH_SEMI, 3'd0, '0, '0, 1'b0, 1'b0)},
			'{"a", 1'b0, 1'b0, '0},
			'{"b", 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, tok(TK_UNKNOWN, 8'h00, 3'd0, '0, '0, 1'b0, 1'b0)},
			'{8'h00, 1'b1, 1'b1, tok(TK_END, 8'h00, 3'd0, '0, '0, 1'b0, 1'b0)}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_char(directed_rows[i].ch, directed_rows[i].eoe, directed_rows[i].typed,
				directed_rows[i].tok);
		wait_drained();

		while (sent < RANDOM_CHARS) begin
			quiet_phase = ($urandom_range(0, 3) == 0);
			build_expr();
			foreach (expr_chars[i])
				send_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, '0);
			sent += expr_chars.size();
			if ($urandom_range(0, 7) == 0) wait_drained();
		end
		char_valid <= 1'b0;

		while (lexed_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("expression_token_lexer test passed");
		end else begin
			$display("expression_token_lexer test failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/etl_pkg.sv
hw/rtl/expression_token_lexer.sv
sim/tb.sv
